>>> src/die_pkg.sv
// Shared types, constants and sequencer states for the diversity index engine.
package die_pkg;

	localparam int MAX_SPECIES_DEF = 64;

	localparam int          DIV_W   = 64;
	localparam int          STEP_W  = 7;
	localparam int          LN_W    = 22;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [18:0] H_MAX   = 19'd327679;
	localparam logic [29:0] TOTAL_MAX = 30'h3FFF_FFFF;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ_WB,
		S_NORM,
		S_SQR_MUL,
		S_SQR_WB,
		S_LN2_MUL,
		S_LN2_WB,
		S_WL_MUL,
		S_WL_WB,
		S_FIN,
		S_H_DIV,
		S_H_WAIT,
		S_S_NORM,
		S_S_MUL,
		S_S_WB,
		S_S_DIV,
		S_S_WAIT,
		S_J_CHK,
		S_J_DIV,
		S_J_WAIT,
		S_EMIT
	} die_state_t;

	typedef enum logic [1:0] {
		LR_ITEM,
		LR_TOTAL,
		LR_RICH
	} die_lnret_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem;
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} die_div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] quo;
	} die_div_sts_t;

endpackage

>>> src/diversity_index_engine_unit.sv
// Diversity index engine top level: accumulation, shared multiplier, log and result sequencer.
//
//  channel | direction | handshake            | word
//  in      | to unit   | in_valid / in_stall  | abundance, active, last
//  out     | from unit | out_valid / out_stall| richness .. evenness
//
// A counted species is normalised by up to 31 one-bit shifts, then squared
// 16 times on the single 32x32 multiplier, a multiply and a write-back state each.
// An item that is not counted does not enter the log steps. Closing a set adds up to two logs
// and up to three passes through the one-bit divider, of 53, 17 and 36 steps.
// Reset clears all sums and the sequencer; no clearing pass.
// in_stall is high whenever the sequencer is not idle; a result waits in the output
// register while out_stall holds it.
module diversity_index_engine_unit
	import die_pkg::*;
#(
	parameter int MAX_SPECIES = MAX_SPECIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] abundance,
	input  logic        active,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  richness,
	output logic [29:0] abund_total,
	output logic [18:0] shannon,
	output logic [15:0] simpson,
	output logic [16:0] evenness
);

	localparam int CNT_W    = $clog2(MAX_SPECIES + 1);
	localparam int SUM_W    = 24 + CNT_W;
	localparam int SQ_W     = 48 + CNT_W;
	localparam int WL_W     = 45 + CNT_W;
	localparam int TW       = ((SUM_W > 32) ? SUM_W : 32) + 1;
	localparam int SH_STEPS = WL_W + 1;
	localparam int EV_STEPS = 36;
	localparam int SP_STEPS = 17;

	die_state_t state_q, state_d;
	die_lnret_t ret_q;

	logic [CNT_W-1:0] idx_q, n_q;
	logic [SUM_W-1:0] t_q;
	logic [SQ_W-1:0]  sq_q, qs_q;
	logic [WL_W-1:0]  wl_q;
	logic [23:0]      a_q;
	logic             last_q;

	logic [TW-1:0]    m_q, ts_q;
	logic [5:0]       e_q;
	logic [15:0]      frac_q;
	logic [3:0]       it_q;
	logic [LN_W-1:0]  ln_q;
	logic [63:0]      den_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p_q;

	logic [18:0] h_q;
	logic [15:0] d_q;
	logic [16:0] j_q;

	logic        out_valid_q;
	logic [6:0]  rich_q;
	logic [29:0] tot_q;
	logic [18:0] sh_q;
	logic [15:0] sd_q;
	logic [16:0] ev_q;

	die_div_req_t div_req;
	die_div_sts_t div_sts;

	logic        accept, elig, m_high, ts_high, simp_zero, emit_go;
	logic [63:0] ln_round, sh_num, ev_num;
	logic [WL_W:0] sh_n;
	logic [35:0]   ev_n;
	logic [LN_W-1:0] h_raw;
	logic [17:0]   sp_r;

	die_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	assign accept    = in_valid && !in_stall;
	assign elig      = (32'(idx_q) < MAX_SPECIES) && active && (abundance != 24'd0);
	assign m_high    = |m_q[TW-1:32];
	assign ts_high   = |ts_q[TW-1:31];
	assign simp_zero = (mul_p_q == 64'd0) || (64'(qs_q) >= mul_p_q);
	assign emit_go   = !out_valid_q || !out_stall;
	assign ln_round  = mul_p_q + 64'h8000_0000;
	assign sh_n      = {1'b0, wl_q} + (WL_W+1)'(t_q >> 1);
	assign sh_num    = 64'(sh_n) << (64 - SH_STEPS);
	assign ev_n      = (36'(h_q) << 16) + 36'(ln_q >> 1);
	assign ev_num    = 64'(ev_n) << (64 - EV_STEPS);
	assign h_raw     = ln_q - div_sts.quo[LN_W-1:0];
	assign sp_r      = (18'(div_sts.quo[16:0]) + 18'd1) >> 1;

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (elig)
						state_d = S_SQ_WB;
					else if (last)
						state_d = S_FIN;
				end
			end
			S_SQ_WB:   state_d = S_NORM;
			S_NORM: begin
				if (!m_high && m_q[31])
					state_d = S_SQR_MUL;
			end
			S_SQR_MUL: state_d = S_SQR_WB;
			S_SQR_WB:  state_d = (it_q == 4'd15) ? S_LN2_MUL : S_SQR_MUL;
			S_LN2_MUL: state_d = S_LN2_WB;
			S_LN2_WB: begin
				case (ret_q)
					LR_ITEM:  state_d = S_WL_MUL;
					LR_TOTAL: state_d = S_H_DIV;
					LR_RICH:  state_d = S_J_DIV;
					default:  state_d = S_IDLE;
				endcase
			end
			S_WL_MUL:  state_d = S_WL_WB;
			S_WL_WB:   state_d = last_q ? S_FIN : S_IDLE;
			S_FIN:     state_d = (n_q == '0) ? S_EMIT : S_NORM;
			S_H_DIV:   state_d = S_H_WAIT;
			S_H_WAIT:  state_d = div_sts.busy ? S_H_WAIT : S_S_NORM;
			S_S_NORM:  state_d = ts_high ? S_S_NORM : S_S_MUL;
			S_S_MUL:   state_d = S_S_WB;
			S_S_WB:    state_d = simp_zero ? S_J_CHK : S_S_DIV;
			S_S_DIV:   state_d = S_S_WAIT;
			S_S_WAIT:  state_d = div_sts.busy ? S_S_WAIT : S_J_CHK;
			S_J_CHK:   state_d = (32'(n_q) > 32'd1) ? S_NORM : S_EMIT;
			S_J_DIV:   state_d = S_J_WAIT;
			S_J_WAIT:  state_d = div_sts.busy ? S_J_WAIT : S_EMIT;
			S_EMIT:    state_d = emit_go ? S_IDLE : S_EMIT;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer: multiplier operands, divider request, stall
	always_comb begin
		in_stall      = (state_q != S_IDLE);
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.rem   = '0;
		div_req.num   = '0;
		div_req.den   = '0;
		div_req.steps = '0;
		case (state_q)
			S_IDLE: begin
				mul_a = 32'(abundance);
				mul_b = 32'(abundance);
			end
			S_SQR_MUL: begin
				mul_a = m_q[31:0];
				mul_b = m_q[31:0];
			end
			S_LN2_MUL: begin
				mul_a = 32'({e_q, frac_q});
				mul_b = LN2_Q32;
			end
			S_WL_MUL: begin
				mul_a = 32'(a_q);
				mul_b = 32'(ln_q);
			end
			S_S_MUL: begin
				mul_a = ts_q[31:0];
				mul_b = ts_q[31:0];
			end
			S_H_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = sh_num;
				div_req.den   = 64'(t_q);
				div_req.steps = STEP_W'(SH_STEPS);
			end
			S_S_DIV: begin
				div_req.start = 1'b1;
				div_req.rem   = 64'(qs_q);
				div_req.den   = den_q;
				div_req.steps = STEP_W'(SP_STEPS);
			end
			S_J_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = ev_num;
				div_req.den   = 64'(ln_q);
				div_req.steps = STEP_W'(EV_STEPS);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			t_q         <= '0;
			sq_q        <= '0;
			wl_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (32'(idx_q) < MAX_SPECIES)
					idx_q <= idx_q + CNT_W'(1);
				if (elig) begin
					n_q <= n_q + CNT_W'(1);
					t_q <= t_q + SUM_W'(abundance);
				end
			end
			if (state_q == S_SQ_WB)
				sq_q <= sq_q + SQ_W'(mul_p_q[47:0]);
			if (state_q == S_WL_WB)
				wl_q <= wl_q + WL_W'(mul_p_q[44:0]);
			if (state_q == S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
				idx_q       <= '0;
				n_q         <= '0;
				t_q         <= '0;
				sq_q        <= '0;
				wl_q        <= '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: log, Shannon, Simpson scaling, evenness and result assembly
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q    <= abundance;
				last_q <= last;
			end
			S_SQ_WB: begin
				m_q   <= TW'(a_q);
				e_q   <= 6'd31;
				it_q  <= '0;
				ret_q <= LR_ITEM;
			end
			S_NORM: begin
				if (m_high) begin
					m_q <= m_q >> 1;
					e_q <= e_q + 6'd1;
				end else if (!m_q[31]) begin
					m_q <= m_q << 1;
					e_q <= e_q - 6'd1;
				end
			end
			S_SQR_WB: begin
				it_q <= it_q + 4'd1;
				if (mul_p_q[63]) begin
					m_q    <= TW'(mul_p_q[63:32]);
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= TW'(mul_p_q[62:31]);
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			S_LN2_WB: ln_q <= ln_round[LN_W+31:32];
			S_FIN: begin
				h_q    <= '0;
				d_q    <= '0;
				j_q    <= '0;
				m_q    <= TW'(t_q);
				e_q    <= 6'd31;
				it_q   <= '0;
				frac_q <= '0;
				ret_q  <= LR_TOTAL;
				ts_q   <= TW'(t_q);
				qs_q   <= sq_q;
			end
			S_H_WAIT: begin
				if (!div_sts.busy) begin
					if (div_sts.quo >= 64'(ln_q))
						h_q <= '0;
					else if (h_raw > LN_W'(H_MAX))
						h_q <= H_MAX;
					else
						h_q <= h_raw[18:0];
				end
			end
			S_S_NORM: begin
				if (ts_high) begin
					ts_q <= ts_q >> 1;
					qs_q <= qs_q >> 2;
				end
			end
			S_S_WB: den_q <= mul_p_q;
			S_S_WAIT: begin
				if (!div_sts.busy) begin
					if (sp_r >= 18'd65536)
						d_q <= '0;
					else if (sp_r == 18'd0)
						d_q <= 16'hFFFF;
					else
						d_q <= 16'(18'd65536 - sp_r);
				end
			end
			S_J_CHK: begin
				m_q   <= TW'(n_q);
				e_q   <= 6'd31;
				it_q  <= '0;
				ret_q <= LR_RICH;
			end
			S_J_WAIT: begin
				if (!div_sts.busy)
					j_q <= (div_sts.quo > 64'd65536) ? 17'd65536 : div_sts.quo[16:0];
			end
			S_EMIT: begin
				if (emit_go) begin
					rich_q <= (32'(n_q) > 32'd127) ? 7'd127 : 7'(n_q);
					tot_q  <= (64'(t_q) > 64'(TOTAL_MAX)) ? TOTAL_MAX : 30'(t_q);
					sh_q   <= h_q;
					sd_q   <= d_q;
					ev_q   <= j_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign richness    = rich_q;
	assign abund_total = tot_q;
	assign shannon     = sh_q;
	assign simpson     = sd_q;
	assign evenness    = ev_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) <= MAX_SPECIES)
		else $error("item index passed the species limit");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> (state_q == S_H_WAIT || state_q == S_S_WAIT || state_q == S_J_WAIT))
		else $error("divider busy outside a wait state");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && richness == 7'd0 |-> abund_total == 30'd0
			&& shannon == 19'd0 && simpson == 16'd0 && evenness == 17'd0)
		else $error("empty set gave a nonzero index");

	a_single_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && richness == 7'd1 |-> evenness == 17'd0)
		else $error("single species gave nonzero evenness");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && emit_go |=> n_q == '0 && idx_q == '0 && out_valid)
		else $error("sums not cleared on result");

endmodule

>>> src/die_div.sv
// Restoring divider: one quotient bit per cycle, shared by all final ratios.
module die_div
	import die_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  die_div_req_t req,
	output die_div_sts_t sts
);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  num_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			num_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= DIV_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.quo  = quo_q;

endmodule

>>> verif/tb_diversity_index_engine_unit.sv
// Self-checking testbench for the diversity index engine: random and directed species sets.
`timescale 1ns / 100ps

class diversity_scoreboard;
	logic [6:0]  counted;
	logic [30:0] abundance_total;
	logic [53:0] squares_total;
	logic [55:0] weighted_log_total;
	int          set_position;
	logic [88:0] pending_results[$];
	int          mismatches;
	int          results_checked;
	int          sets_closed;

	function new();
		clear_set();
		mismatches = 0;
		results_checked = 0;
		sets_closed = 0;
	endfunction

	function void clear_set();
		counted = 0;
		abundance_total = 0;
		squares_total = 0;
		weighted_log_total = 0;
		set_position = 0;
	endfunction

	function automatic int lead_one(logic [63:0] x);
		int e;
		e = 0;
		while (e < 63 && (x >> (e + 1)) != 0)
			e++;
		return e;
	endfunction

	// ln(x) in Q.16 through log2 by repeated squaring
	function automatic logic [63:0] ln_q16(logic [63:0] x);
		int          e;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] l2;
		logic [127:0] prod;
		if (x == 0)
			x = 1;
		e = lead_one(x);
		frac = 0;
		m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		l2 = (64'(e) << 16) | frac;
		prod = 128'(l2) * 128'd2977044472 + (128'd1 << 31);
		return prod[95:32];
	endfunction

	function automatic logic [63:0] simpson_q16(logic [63:0] t, logic [63:0] q);
		int          s;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] r;
		s = 0;
		r = 0;
		if (t >= 64'h8000_0000)
			s = lead_one(t) - 30;
		t = t >> s;
		q = (2 * s < 64) ? (q >> (2 * s)) : 0;
		den = t * t;
		if (den == 0 || q >= den)
			return 0;
		num = q;
		for (int i = 0; i < 17; i++) begin
			num = num << 1;
			r = r << 1;
			if (num >= den) begin
				num = num - den;
				r[0] = 1'b1;
			end
		end
		r = (r + 1) >> 1;
		if (r >= 65536)
			return 0;
		r = 65536 - r;
		return (r > 65535) ? 65535 : r;
	endfunction

	function void note_word(logic [23:0] a, logic act, logic lst);
		logic [63:0] t, n, lnt, q, h, d, j, ls;
		if (set_position < die_pkg::MAX_SPECIES_DEF) begin
			if (act && a != 0) begin
				counted++;
				abundance_total += a;
				squares_total += 54'(a) * 54'(a);
				weighted_log_total += 56'(a) * 56'(ln_q16(a));
			end
			set_position++;
		end
		if (!lst)
			return;
		n = counted;
		t = abundance_total;
		h = 0;
		d = 0;
		j = 0;
		if (n != 0 && t != 0) begin
			lnt = ln_q16(t);
			q = (64'(weighted_log_total) + t / 2) / t;
			h = (q >= lnt) ? 0 : lnt - q;
			if (h > 327679)
				h = 327679;
			d = simpson_q16(t, 64'(squares_total));
			if (n > 1) begin
				ls = ln_q16(n);
				j = ((h << 16) + ls / 2) / ls;
				if (j > 65536)
					j = 65536;
			end
		end
		pending_results.push_back({n[6:0], (t > 64'h3FFF_FFFF) ? 30'h3FFF_FFFF : t[29:0],
			h[18:0], d[15:0], j[16:0]});
		sets_closed++;
		clear_set();
	endfunction

	function void check_result(logic [88:0] got);
		logic [88:0] exp_word;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word %h", got);
			return;
		end
		exp_word = pending_results.pop_front();
		results_checked++;
		if (got !== exp_word) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: rich %0d/%0d total %0d/%0d H %0d/%0d D %0d/%0d J %0d/%0d",
					got[88:82], exp_word[88:82], got[81:52], exp_word[81:52],
					got[51:33], exp_word[51:33], got[32:17], exp_word[32:17],
					got[16:0], exp_word[16:0]);
		end
	endfunction
endclass

module tb_diversity_index_engine_unit;
	import die_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [23:0] abundance;
	logic        active;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [6:0]  richness;
	logic [29:0] abund_total;
	logic [18:0] shannon;
	logic [15:0] simpson;
	logic [16:0] evenness;

	diversity_scoreboard board;
	int  cycle_count = 0;
	bit  calm_stretch;

	diversity_index_engine_unit u_dut (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// accept results and stall the output at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				board.check_result({richness, abund_total, shannon,
					simpson, evenness});
			out_stall <= calm_stretch ? 1'b0 : ($urandom_range(0, 99) < 24);
		end
	end

	// send one word, idling at random first
	task automatic send_word(logic [23:0] a, logic act, logic lst);
		while (!calm_stretch && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		abundance <= a;
		active <= act;
		last <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_word(a, act, lst);
	endtask

	function automatic logic [23:0] rand_abundance();
		case ($urandom_range(0, 5))
			0: return 24'($urandom_range(1, 255));
			1: return 24'hFFFFFF - 24'($urandom_range(0, 255));
			2: return 24'($urandom_range(1, 16)) << $urandom_range(0, 19);
			3: return 24'd0;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_random_set(output int len);
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			send_word(rand_abundance(), $urandom_range(0, 9) != 0, i == len - 1);
	endtask

	initial begin
		int sent;
		int len;
		board = new();
		calm_stretch = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		abundance = '0;
		active = 1'b0;
		last = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, inactive and zero words, single species
		send_word(24'd0, 1'b0, 1'b1);
		send_word(24'd500, 1'b0, 1'b0);
		send_word(24'd0, 1'b1, 1'b1);
		send_word(24'hFFFFFF, 1'b1, 1'b1);
		send_word(24'd1, 1'b1, 1'b1);
		// even pair and skewed pair
		send_word(24'd256, 1'b1, 1'b0);
		send_word(24'd256, 1'b1, 1'b1);
		send_word(24'd1, 1'b1, 1'b0);
		send_word(24'hFFFFFF, 1'b1, 1'b1);
		// four maximal species in one set; the total still fits its field
		for (int i = 0; i < 4; i++)
			send_word(24'hFFFFFF, 1'b1, i == 3);
		sent = 13;
		// more than the species limit: later words are dropped but last still closes
		for (int i = 0; i < 70; i++)
			send_word(24'hFFFFFF - 24'(i), 1'b1, i == 69);
		sent += 70;

		while (sent < 900) begin
			if (sent > 300 && sent < 450)
				calm_stretch = 1'b1;
			else
				calm_stretch = 1'b0;
			send_random_set(len);
			sent += len;
		end
		in_valid <= 1'b0;
		calm_stretch = 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		$display("covered %0d sets, %0d results checked, %0d mismatches",
			board.sets_closed, board.results_checked, board.mismatches);
		if (board.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

>>> files.f
src/die_pkg.sv
src/die_div.sv
src/diversity_index_engine_unit.sv
verif/tb_diversity_index_engine_unit.sv
